/* rtl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helper functions for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int LENGTH_BITS_DEF = 16;

    // status codes
    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_BAD_ESC  = 3'd2;
    localparam logic [2:0] ST_CTRL     = 3'd3;
    localparam logic [2:0] ST_MISSING  = 3'd4;
    localparam logic [2:0] ST_BAD_HEX  = 3'd5;
    localparam logic [2:0] ST_BAD_SURR = 3'd6;
    localparam logic [2:0] ST_OUTSIDE  = 3'd7;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_STR,
        PH_ESC,
        PH_HEX,
        PH_LOW_BS,
        PH_LOW_U
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [11:0] hex_value;
        logic [1:0]  hex_digit_count;
        logic [9:0]  high_half;
        logic        in_low_escape;
    } dec_state_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      cnt_m1;
    } enc_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      cnt_m1;
        logic            data;
        logic [2:0]      status;
        logic            clr_count;
    } dec_res_t;

    // bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    // code point to utf-8, first byte in bytes[0]
    function automatic enc_t utf8_encode(input logic [20:0] u);
        enc_t e;
        e.bytes = '0;
        if (u <= 21'h7F) begin
            e.cnt_m1   = 2'd0;
            e.bytes[0] = {1'b0, u[6:0]};
        end else if (u <= 21'h7FF) begin
            e.cnt_m1   = 2'd1;
            e.bytes[0] = {3'b110, u[10:6]};
            e.bytes[1] = {2'b10, u[5:0]};
        end else if (u <= 21'hFFFF) begin
            e.cnt_m1   = 2'd2;
            e.bytes[0] = {4'b1110, u[15:12]};
            e.bytes[1] = {2'b10, u[11:6]};
            e.bytes[2] = {2'b10, u[5:0]};
        end else begin
            e.cnt_m1   = 2'd3;
            e.bytes[0] = {5'b11110, u[20:18]};
            e.bytes[1] = {2'b10, u[17:12]};
            e.bytes[2] = {2'b10, u[11:6]};
            e.bytes[3] = {2'b10, u[5:0]};
        end
        return e;
    endfunction

endpackage

/* rtl/jsu_decode.sv */
// ----------------------------------------------------------------------------
// jsu_decode
// Next-state and result logic for one text byte of the unescaper.
// ----------------------------------------------------------------------------
module jsu_decode
    import jsu_pkg::*;
(
    input  dec_state_t st,
    input  logic [7:0] c,
    output dec_state_t st_next,
    output dec_res_t   res
);

    logic [4:0]  nib;
    logic [15:0] u;
    enc_t        enc_single;
    enc_t        enc_pair;

    assign nib        = hex_nibble(c);
    assign u          = {st.hex_value, nib[3:0]};
    assign enc_single = utf8_encode(21'(u));
    assign enc_pair   = utf8_encode(21'({st.high_half, u[9:0]}) + 21'h10000);

    always_comb begin
        st_next       = st;
        res.bytes     = '0;
        res.cnt_m1    = 2'd0;
        res.data      = 1'b0;
        res.status    = ST_BUSY;
        res.clr_count = 1'b0;

        unique case (st.phase)
            PH_IDLE: begin
                if (c == CH_QUOTE) begin
                    res.clr_count = 1'b1;
                    st_next.phase = PH_STR;
                end else begin
                    res.status = ST_OUTSIDE;
                end
            end
            PH_STR: begin
                if (c == CH_QUOTE) begin
                    res.status    = ST_DONE;
                    st_next.phase = PH_IDLE;
                end else if (c == CH_BSLASH) begin
                    st_next.phase = PH_ESC;
                end else if (c == CH_NUL) begin
                    res.status    = ST_MISSING;
                    st_next.phase = PH_IDLE;
                end else if (c < CH_SPACE) begin
                    res.status    = ST_CTRL;
                    st_next.phase = PH_IDLE;
                end else begin
                    res.data     = 1'b1;
                    res.bytes[0] = c;
                end
            end
            PH_ESC: begin
                st_next.phase = PH_STR;
                res.data      = 1'b1;
                case (c)
                    CH_QUOTE:  res.bytes[0] = CH_QUOTE;
                    CH_BSLASH: res.bytes[0] = CH_BSLASH;
                    CH_SLASH:  res.bytes[0] = CH_SLASH;
                    CH_B:      res.bytes[0] = 8'h08;
                    CH_F:      res.bytes[0] = 8'h0C;
                    CH_N:      res.bytes[0] = 8'h0A;
                    CH_R:      res.bytes[0] = 8'h0D;
                    CH_T:      res.bytes[0] = 8'h09;
                    CH_U: begin
                        res.data                = 1'b0;
                        st_next.phase           = PH_HEX;
                        st_next.in_low_escape   = 1'b0;
                        st_next.hex_value       = '0;
                        st_next.hex_digit_count = '0;
                    end
                    default: begin
                        res.data      = 1'b0;
                        res.status    = ST_BAD_ESC;
                        st_next.phase = PH_IDLE;
                    end
                endcase
            end
            PH_HEX: begin
                if (!nib[4]) begin
                    res.status    = ST_BAD_HEX;
                    st_next.phase = PH_IDLE;
                end else if (st.hex_digit_count != 2'd3) begin
                    st_next.hex_value       = u[11:0];
                    st_next.hex_digit_count = st.hex_digit_count + 2'd1;
                end else begin
                    st_next.hex_value       = '0;
                    st_next.hex_digit_count = '0;
                    if (st.in_low_escape) begin
                        st_next.in_low_escape = 1'b0;
                        if (u < 16'hDC00 || u > 16'hDFFF) begin
                            res.status    = ST_BAD_SURR;
                            st_next.phase = PH_IDLE;
                        end else begin
                            st_next.phase = PH_STR;
                            res.data      = 1'b1;
                            res.bytes     = enc_pair.bytes;
                            res.cnt_m1    = enc_pair.cnt_m1;
                        end
                    end else if (u >= 16'hD800 && u <= 16'hDBFF) begin
                        st_next.high_half = u[9:0];
                        st_next.phase     = PH_LOW_BS;
                    end else begin
                        st_next.phase = PH_STR;
                        res.data      = 1'b1;
                        res.bytes     = enc_single.bytes;
                        res.cnt_m1    = enc_single.cnt_m1;
                    end
                end
            end
            PH_LOW_BS: begin
                if (c == CH_BSLASH) begin
                    st_next.phase = PH_LOW_U;
                end else begin
                    res.status    = ST_BAD_SURR;
                    st_next.phase = PH_IDLE;
                end
            end
            PH_LOW_U: begin
                if (c == CH_U) begin
                    st_next.phase           = PH_HEX;
                    st_next.in_low_escape   = 1'b1;
                    st_next.hex_value       = '0;
                    st_next.hex_digit_count = '0;
                end else begin
                    res.status    = ST_BAD_SURR;
                    st_next.phase = PH_IDLE;
                end
            end
            default: begin
                res.status    = ST_OUTSIDE;
                st_next.phase = PH_IDLE;
            end
        endcase
    end

endmodule

/* rtl/json_string_unescape.sv */
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming JSON string unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// One text byte enters per cycle, while s_ready is high, into an input
// register; the decode logic turns it into 1 to 4 results, loaded together
// into an output register that gives one per cycle while m_ready is high,
// the final one flagged by m_last. A byte that yields one result (everything
// except a \u escape that produces a multi-byte UTF-8 character) allows one
// byte per cycle with m_ready high; a character that encodes to N bytes
// holds the input while the output register drains. After an error status
// the bytes already given for that string are to be discarded.
module json_string_unescape
    import jsu_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic [2:0]  m_status,
    output logic [15:0] m_string_length,
    output logic        m_last
);

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    dec_state_t             state_reg, state_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic                   out_valid_reg;
    dec_res_t               res_reg, res_next;
    logic [15:0]            len_reg, len_next;
    logic [1:0]             idx_reg;

    logic                   load;
    logic                   drain_done;
    logic [LENGTH_BITS:0]   count_sum;
    logic [2:0]             n_data;
    logic [31:0]            count_wide;

    jsu_decode u_decode (
        .st      (state_reg),
        .c       (in_byte_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    assign m_last     = (idx_reg == res_reg.cnt_m1);
    assign drain_done = out_valid_reg && m_ready && m_last;
    assign load       = in_valid_reg && (!out_valid_reg || drain_done);
    assign s_ready    = !in_valid_reg || load;

    assign m_valid         = out_valid_reg;
    assign m_out_byte      = res_reg.data ? res_reg.bytes[idx_reg] : 8'h00;
    assign m_byte_valid    = res_reg.data;
    assign m_status        = res_reg.status;
    assign m_string_length = len_reg;

    // length saturation
    assign n_data     = res_next.data ? {1'b0, res_next.cnt_m1} + 3'd1 : 3'd0;
    assign count_sum  = {1'b0, count_reg} + (LENGTH_BITS+1)'(n_data);
    assign count_wide = 32'(count_reg);

    always_comb begin
        if (res_next.clr_count) begin
            count_next = '0;
        end else if (count_sum > {1'b0, COUNT_MAX}) begin
            count_next = COUNT_MAX;
        end else begin
            count_next = count_sum[LENGTH_BITS-1:0];
        end
        if (res_next.status != ST_DONE) begin
            len_next = 16'd0;
        end else if (count_wide > 32'hFFFF) begin
            len_next = 16'hFFFF;
        end else begin
            len_next = count_wide[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            idx_reg               <= 2'd0;
            count_reg             <= '0;
            state_reg.phase           <= PH_IDLE;
            state_reg.hex_value       <= '0;
            state_reg.hex_digit_count <= '0;
            state_reg.high_half       <= '0;
            state_reg.in_low_escape   <= 1'b0;
        end else begin
            // input register
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_in_byte;
            end else if (load) begin
                in_valid_reg <= 1'b0;
            end

            // output register
            if (load) begin
                out_valid_reg <= 1'b1;
                res_reg       <= res_next;
                len_reg       <= len_next;
                idx_reg       <= 2'd0;
                state_reg     <= state_next;
                count_reg     <= count_next;
            end else if (drain_done) begin
                out_valid_reg <= 1'b0;
            end else if (out_valid_reg && m_ready) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming JSON string unescaper.
// ----------------------------------------------------------------------------
// Text bytes go in over the s_ channel. Each accepted byte runs through a
// local decoder model that queues the result transactions it should cause.
// Every m_ transaction is compared field by field with the oldest queued one.
// A short directed table comes first, then randomly built strings. These mix
// escapes, \u code points of every UTF-8 width and surrogate pairs with
// broken sequences and noise outside strings. Both sides throttle at random,
// the receiver once stalls for a long stretch, and a watchdog catches hangs.
// ----------------------------------------------------------------------------
module tb_top;
    import jsu_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [2:0]  status;
        logic [15:0] string_length;
        logic        last;
    } unesc_res_t;

    typedef struct packed {
        logic [7:0]  b;
        logic        typed;
        logic [2:0]  st;
        logic [15:0] len;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_byte_valid;
    logic [2:0]  m_status;
    logic [15:0] m_string_length;
    logic        m_last;

    // decoder model state
    phase_t      dec_phase = PH_IDLE;
    logic [15:0] acc_hex = '0;
    logic [1:0]  acc_digits = '0;
    logic [9:0]  pair_hi = '0;
    logic        want_low = 1'b0;
    logic [15:0] char_count = '0;

    unesc_res_t  step_q[$];
    unesc_res_t  decoded_q[$];
    logic [7:0]  text_q[$];

    int          src_idle = 0;
    int          sink_idle = 0;
    int          hold_ticket = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          quiet = 0;
    int          n_err = 0;
    int          n_bytes_in = 0;
    int          n_checked = 0;
    logic [7:0]  status_seen = '0;

    dir_row_t dir_tbl [0:23] = '{
        '{CH_NUL,    1'b1, ST_OUTSIDE, 16'd0},
        '{8'hFF,     1'b1, ST_OUTSIDE, 16'd0},
        '{CH_QUOTE,  1'b1, ST_BUSY,    16'd0},
        '{8'h41,     1'b0, ST_BUSY,    16'd0},
        '{8'hFF,     1'b0, ST_BUSY,    16'd0},
        '{CH_BSLASH, 1'b0, ST_BUSY,    16'd0},
        '{CH_N,      1'b0, ST_BUSY,    16'd0},
        '{CH_BSLASH, 1'b0, ST_BUSY,    16'd0},
        '{CH_U,      1'b0, ST_BUSY,    16'd0},
        '{8'h44,     1'b0, ST_BUSY,    16'd0},
        '{8'h38,     1'b0, ST_BUSY,    16'd0},
        '{8'h33,     1'b0, ST_BUSY,    16'd0},
        '{8'h44,     1'b0, ST_BUSY,    16'd0},
        '{CH_BSLASH, 1'b0, ST_BUSY,    16'd0},
        '{CH_U,      1'b0, ST_BUSY,    16'd0},
        '{8'h64,     1'b0, ST_BUSY,    16'd0},
        '{8'h65,     1'b0, ST_BUSY,    16'd0},
        '{8'h30,     1'b0, ST_BUSY,    16'd0},
        '{8'h30,     1'b0, ST_BUSY,    16'd0},
        '{CH_QUOTE,  1'b1, ST_DONE,    16'd7},
        '{CH_QUOTE,  1'b1, ST_BUSY,    16'd0},
        '{8'h1F,     1'b1, ST_CTRL,    16'd0},
        '{CH_QUOTE,  1'b1, ST_BUSY,    16'd0},
        '{CH_NUL,    1'b1, ST_MISSING, 16'd0}
    };

    json_string_unescape dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_status        (m_status),
        .m_string_length (m_string_length),
        .m_last          (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, c[3:0]};
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    task automatic add_res(input logic [7:0] b, input logic v, input logic [2:0] st,
                           input logic [15:0] len);
        unesc_res_t r;
        r = '{b, v, st, len, 1'b0};
        step_q.push_back(r);
    endtask

    task automatic add_data(input logic [7:0] b);
        add_res(b, 1'b1, ST_BUSY, 16'd0);
        if (char_count != 16'hFFFF) begin
            char_count = char_count + 16'd1;
        end
    endtask

    task automatic abort_str(input logic [2:0] st);
        add_res(8'd0, 1'b0, st, 16'd0);
        dec_phase = PH_IDLE;
    endtask

    task automatic add_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            add_data({1'b0, cp[6:0]});
        end else if (cp < 21'h800) begin
            add_data({3'b110, cp[10:6]});
            add_data({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            add_data({4'b1110, cp[15:12]});
            add_data({2'b10, cp[11:6]});
            add_data({2'b10, cp[5:0]});
        end else begin
            add_data({5'b11110, cp[20:18]});
            add_data({2'b10, cp[17:12]});
            add_data({2'b10, cp[11:6]});
            add_data({2'b10, cp[5:0]});
        end
    endtask

    task automatic decode_byte(input logic [7:0] c);
        logic [4:0]  hx;
        logic [15:0] u;
        unesc_res_t  tail;
        step_q.delete();
        case (dec_phase)
            PH_IDLE: begin
                if (c == CH_QUOTE) begin
                    char_count = '0;
                    dec_phase = PH_STR;
                    add_res(8'd0, 1'b0, ST_BUSY, 16'd0);
                end else begin
                    add_res(8'd0, 1'b0, ST_OUTSIDE, 16'd0);
                end
            end
            PH_STR: begin
                if (c == CH_QUOTE) begin
                    add_res(8'd0, 1'b0, ST_DONE, char_count);
                    dec_phase = PH_IDLE;
                end else if (c == CH_BSLASH) begin
                    dec_phase = PH_ESC;
                    add_res(8'd0, 1'b0, ST_BUSY, 16'd0);
                end else if (c == CH_NUL) begin
                    abort_str(ST_MISSING);
                end else if (c < CH_SPACE) begin
                    abort_str(ST_CTRL);
                end else begin
                    add_data(c);
                end
            end
            PH_ESC: begin
                dec_phase = PH_STR;
                case (c)
                    CH_QUOTE:  add_data(CH_QUOTE);
                    CH_BSLASH: add_data(CH_BSLASH);
                    CH_SLASH:  add_data(CH_SLASH);
                    CH_B:      add_data(8'h08);
                    CH_F:      add_data(8'h0C);
                    CH_N:      add_data(8'h0A);
                    CH_R:      add_data(8'h0D);
                    CH_T:      add_data(8'h09);
                    CH_U: begin
                        dec_phase = PH_HEX;
                        want_low = 1'b0;
                        acc_hex = '0;
                        acc_digits = '0;
                        add_res(8'd0, 1'b0, ST_BUSY, 16'd0);
                    end
                    default: abort_str(ST_BAD_ESC);
                endcase
            end
            PH_HEX: begin
                hx = hex_val(c);
                if (!hx[4]) begin
                    abort_str(ST_BAD_HEX);
                end else begin
                    u = {acc_hex[11:0], hx[3:0]};
                    if (acc_digits != 2'd3) begin
                        acc_hex = u;
                        acc_digits = acc_digits + 2'd1;
                        add_res(8'd0, 1'b0, ST_BUSY, 16'd0);
                    end else begin
                        acc_hex = '0;
                        acc_digits = '0;
                        if (want_low) begin
                            want_low = 1'b0;
                            if (u < 16'hDC00 || u > 16'hDFFF) begin
                                abort_str(ST_BAD_SURR);
                            end else begin
                                dec_phase = PH_STR;
                                add_utf8(21'({pair_hi, u[9:0]}) + 21'h10000);
                            end
                        end else if (u >= 16'hD800 && u <= 16'hDBFF) begin
                            pair_hi = u[9:0];
                            dec_phase = PH_LOW_BS;
                            add_res(8'd0, 1'b0, ST_BUSY, 16'd0);
                        end else begin
                            dec_phase = PH_STR;
                            add_utf8({5'd0, u});
                        end
                    end
                end
            end
            PH_LOW_BS: begin
                if (c == CH_BSLASH) begin
                    dec_phase = PH_LOW_U;
                    add_res(8'd0, 1'b0, ST_BUSY, 16'd0);
                end else begin
                    abort_str(ST_BAD_SURR);
                end
            end
            PH_LOW_U: begin
                if (c == CH_U) begin
                    dec_phase = PH_HEX;
                    want_low = 1'b1;
                    acc_hex = '0;
                    acc_digits = '0;
                    add_res(8'd0, 1'b0, ST_BUSY, 16'd0);
                end else begin
                    abort_str(ST_BAD_SURR);
                end
            end
            default: begin
                dec_phase = PH_IDLE;
                add_res(8'd0, 1'b0, ST_OUTSIDE, 16'd0);
            end
        endcase
        tail = step_q.pop_back();
        tail.last = 1'b1;
        step_q.push_back(tail);
    endtask

    // ------------------------------------------------------------------------
    // text generation
    // ------------------------------------------------------------------------
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + 8'(n);
        end
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] esc_pick(input int i);
        case (i)
            0:       return CH_QUOTE;
            1:       return CH_BSLASH;
            2:       return CH_SLASH;
            3:       return CH_B;
            4:       return CH_F;
            5:       return CH_N;
            6:       return CH_R;
            default: return CH_T;
        endcase
    endfunction

    function automatic bit is_esc(input logic [7:0] c);
        return c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_B ||
               c == CH_F || c == CH_N || c == CH_R || c == CH_T || c == CH_U;
    endfunction

    task automatic push_u(input logic [15:0] v);
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_U);
        for (int i = 3; i >= 0; i--) begin
            text_q.push_back(hex_char(v[i*4 +: 4]));
        end
    endtask

    task automatic push_non_hex();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (hex_val(c) != 5'd0) begin
            c = 8'($urandom_range(255));
        end
        text_q.push_back(c);
    endtask

    task automatic push_partial_hex();
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_U);
        repeat ($urandom_range(0, 3)) text_q.push_back(hex_char(4'($urandom_range(15))));
        push_non_hex();
    endtask

    // one string, mostly well formed; returns how many bytes belong to it
    task automatic gen_string(output int useful);
        int          r;
        int          start;
        logic [7:0]  c;
        logic [15:0] v;
        start = text_q.size();
        text_q.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 8)) begin
            r = $urandom_range(99);
            if (r < 40) begin
                c = 8'($urandom_range(32, 255));
                while (c == CH_QUOTE || c == CH_BSLASH) c = 8'($urandom_range(32, 255));
                text_q.push_back(c);
            end else if (r < 55) begin
                text_q.push_back(CH_BSLASH);
                text_q.push_back(esc_pick($urandom_range(7)));
            end else if (r < 64) begin
                push_u(16'($urandom_range(16'h7F)));
            end else if (r < 73) begin
                push_u(16'($urandom_range(16'h80, 16'h7FF)));
            end else if (r < 82) begin
                v = 16'($urandom_range(16'h800, 16'hFFFF));
                if (v >= 16'hD800 && v <= 16'hDBFF) v = v + 16'h0400;
                push_u(v);
            end else if (r < 88) begin
                push_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end else begin
                push_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                push_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
        end
        if ($urandom_range(99) < 65) begin
            text_q.push_back(CH_QUOTE);
        end else begin
            case ($urandom_range(7))
                0: begin
                    text_q.push_back(CH_BSLASH);
                    c = 8'($urandom_range(255));
                    while (is_esc(c)) c = 8'($urandom_range(255));
                    text_q.push_back(c);
                end
                1: text_q.push_back(8'($urandom_range(1, 31)));
                2: text_q.push_back(CH_NUL);
                3: push_partial_hex();
                4: begin
                    push_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                    c = 8'($urandom_range(255));
                    while (c == CH_BSLASH) c = 8'($urandom_range(255));
                    text_q.push_back(c);
                end
                5: begin
                    push_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                    text_q.push_back(CH_BSLASH);
                    c = 8'($urandom_range(255));
                    while (c == CH_U) c = 8'($urandom_range(255));
                    text_q.push_back(c);
                end
                6: begin
                    push_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                    v = 16'($urandom_range(16'hFFFF));
                    if (v >= 16'hDC00 && v <= 16'hDFFF) v = v ^ 16'h2000;
                    push_u(v);
                end
                default: begin
                    push_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                    push_partial_hex();
                end
            endcase
        end
        useful = text_q.size() - start;
        // stray bytes between strings
        if ($urandom_range(99) < 25) begin
            repeat ($urandom_range(1, 3)) begin
                c = 8'($urandom_range(255));
                while (c == CH_QUOTE) c = 8'($urandom_range(255));
                text_q.push_back(c);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task automatic send(input logic [7:0] b, input logic typed, input logic [2:0] st,
                        input logic [15:0] len);
        unesc_res_t r;
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        decode_byte(b);
        if (typed) begin
            r = '{8'd0, 1'b0, st, len, 1'b1};
            step_q.delete();
            step_q.push_back(r);
        end
        foreach (step_q[i]) decoded_q.push_back(step_q[i]);
        n_bytes_in++;
    endtask

    task automatic run_random(input int target);
        int done_cnt;
        int useful;
        done_cnt = 0;
        while (done_cnt < target) begin
            text_q.delete();
            gen_string(useful);
            foreach (text_q[i]) send(text_q[i], 1'b0, ST_BUSY, 16'd0);
            done_cnt += useful;
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (decoded_q.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_ticket != hold_seen) begin
            hold_seen <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle);
        end
    end

    always @(posedge aclk) begin
        unesc_res_t got;
        unesc_res_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_out_byte, m_byte_valid, m_status, m_string_length, m_last};
            n_checked++;
            status_seen[m_status] = 1'b1;
            if (decoded_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) begin
                    $display("tb_top: unexpected transaction byte=%02h v=%0d st=%0d len=%0d",
                             got.out_byte, got.byte_valid, got.status, got.string_length);
                end
            end else begin
                want = decoded_q.pop_front();
                if (got !== want) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("tb_top: mismatch exp byte=%02h v=%0d st=%0d len=%0d last=%0d",
                                 want.out_byte, want.byte_valid, want.status,
                                 want.string_length, want.last);
                        $display("tb_top:          got byte=%02h v=%0d st=%0d len=%0d last=%0d",
                                 got.out_byte, got.byte_valid, got.status,
                                 got.string_length, got.last);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("tb_top: no transaction for %0d cycles", QUIET_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle  = 26;
        sink_idle = 73;
        foreach (dir_tbl[i]) begin
            send(dir_tbl[i].b, dir_tbl[i].typed, dir_tbl[i].st, dir_tbl[i].len);
        end
        run_random(85);
        drain();

        src_idle  = 73;
        sink_idle = 26;
        run_random(65);

        // long receiver stall while text keeps coming
        src_idle  = 0;
        sink_idle = 0;
        hold_ticket <= hold_ticket + 1;
        run_random(45);
        drain();

        src_idle  = 0;
        sink_idle = 0;
        run_random(35);

        drain();
        repeat (20) @(posedge aclk);

        $display("tb_top: %0d text bytes sent, %0d result transactions checked, %0d bad",
                 n_bytes_in, n_checked, n_err);
        $display("tb_top: status codes seen %b, one long receiver stall and full drains",
                 status_seen);
        if (n_err == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
